### rtl/core/rainbow_strip_frame_generator_assert.svh
// Assertion macros used by the rainbow strip frame generator RTL.
`ifndef RAINBOW_STRIP_FRAME_GENERATOR_ASSERT_SVH
`define RAINBOW_STRIP_FRAME_GENERATOR_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define RSFG_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define RSFG_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

### rtl/core/rsfg_pkg.sv
// Package with the constants, types and color wheel function of the rainbow strip generator.
package rsfg_pkg;

   localparam int MAX_PIXELS_DEFAULT = 16;
   localparam int PIXEL_COUNT_W      = 5;
   localparam int SPREAD_W           = 8;
   localparam int PHASE_W            = 11;
   localparam int LEVEL_W            = 5;
   localparam int INDEX_W            = 4;
   localparam int REQ_DATA_W         = 8;
   localparam int RSP_DATA_W         = 24;

   localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET = 5'd14;
   localparam logic [PHASE_W-1:0]       PHASE_WRAP        = 11'd1280;
   localparam logic [7:0]               SEGMENT_ONE       = 8'd85;
   localparam logic [7:0]               SEGMENT_TWO       = 8'd170;
   localparam logic [7:0]               FULL_SCALE        = 8'd255;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } color_type;

   // Maps a hue onto the three-segment wheel and keeps the top five bits of each channel.
   function automatic color_type color_wheel(input logic [7:0] hue);
      logic [7:0] w;
      logic [7:0] off;
      logic [9:0] triple;
      logic [7:0] rising;
      logic [7:0] falling;
      color_type  c;
      w = FULL_SCALE - hue;
      if (w < SEGMENT_ONE) begin
         off = w;
      end else if (w < SEGMENT_TWO) begin
         off = w - SEGMENT_ONE;
      end else begin
         off = w - SEGMENT_TWO;
      end
      triple  = {2'b00, off} + {1'b0, off, 1'b0};
      rising  = triple[7:0];
      falling = FULL_SCALE - rising;
      if (w < SEGMENT_ONE) begin
         c.red   = falling[7:3];
         c.green = '0;
         c.blue  = rising[7:3];
      end else if (w < SEGMENT_TWO) begin
         c.red   = '0;
         c.green = rising[7:3];
         c.blue  = falling[7:3];
      end else begin
         c.red   = rising[7:3];
         c.green = falling[7:3];
         c.blue  = '0;
      end
      return c;
   endfunction

endpackage

### rtl/core/rainbow_strip_frame_generator.sv
// Rainbow strip frame generator: one frame request in, one colored pixel out per strip position.
// Each pixel is computed one quotient bit per cycle by the shared restoring divider, then the
// wheel mapping is loaded into the output register once the output is free (not stalled).
// The first pixel is registered after the divider steps that follow the request transaction,
// and the next request is taken once the last pixel of the frame is loaded.
// Synchronous reset clears phase, sequencer, valid; pixel count is 14.
`include "rainbow_strip_frame_generator_assert.svh"

module rainbow_strip_frame_generator #(
   parameter int MAX_PIXELS = rsfg_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rsfg_pkg::PIXEL_COUNT_W-1:0] csr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rsfg_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] spread
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rsfg_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [3:0] pixel_index, [8:4] blue_level,
                                                       // [13:9] green_level, [18:14] red_level
   output logic                            rsp_tlast   // last_pixel
);

   localparam int CNT_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT1_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS + 1) : 1;
   localparam int CMP_W  = (CNT1_W > rsfg_pkg::PIXEL_COUNT_W) ? CNT1_W : rsfg_pkg::PIXEL_COUNT_W;
   localparam int NUM_W  = CNT_W + 8;
   localparam int STEP_W = $clog2(NUM_W);
   localparam int IDXX_W = CNT_W + rsfg_pkg::INDEX_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_MAP    = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [rsfg_pkg::PIXEL_COUNT_W-1:0]  pixel_count_ff, pixel_count_in;
   logic [rsfg_pkg::PHASE_W-1:0]        phase_ff, phase_in;
   logic [7:0]                          spread_ff, spread_in;
   logic [CNT1_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                    pixel_ff, pixel_in;
   logic [NUM_W-1:0]                    dividend_ff, dividend_in;
   logic [7:0]                          rem_ff, rem_in;
   logic [7:0]                          quo_ff, quo_in;
   logic [STEP_W-1:0]                   step_ff, step_in;
   logic [7:0]                          hue_ff, hue_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rsfg_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                req_accept;
   logic [CMP_W-1:0]                    count_cmp;
   logic [CNT1_W-1:0]                   count_sat;
   logic [rsfg_pkg::PHASE_W-1:0]        phase_inc;
   logic [8:0]                          rem_shift;
   logic [8:0]                          rem_diff;
   logic                                quo_bit;
   logic [7:0]                          quo_next;
   logic                                out_free;
   logic                                out_load;
   logic                                pixel_last;
   logic [IDXX_W-1:0]                   pixel_ext;
   rsfg_pkg::color_type                 color;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign count_cmp = CMP_W'(pixel_count_ff);
   assign count_sat = (count_cmp > CMP_W'(MAX_PIXELS)) ? CNT1_W'(MAX_PIXELS)
                                                       : CNT1_W'(count_cmp);
   assign phase_inc = phase_ff + rsfg_pkg::PHASE_W'(1);

   // One restoring division step per cycle; only the low eight quotient bits matter for the hue.
   assign rem_shift = {rem_ff, dividend_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, spread_ff};
   assign quo_bit   = (rem_shift >= {1'b0, spread_ff});
   assign quo_next  = {quo_ff[6:0], quo_bit};

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_MAP) && out_free;
   assign pixel_last = ((CNT1_W'(pixel_ff) + CNT1_W'(1)) == count_ff);
   assign pixel_ext  = IDXX_W'(pixel_ff);
   assign color      = rsfg_pkg::color_wheel(hue_ff);

   always_comb begin
      state_in       = state_ff;
      pixel_count_in = pixel_count_ff;
      phase_in       = phase_ff;
      spread_in      = spread_ff;
      count_in       = count_ff;
      pixel_in       = pixel_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      hue_in         = hue_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (csr_valid && csr_ready) begin
         pixel_count_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               spread_in   = (req_tdata[7:0] == 8'd0) ? 8'd1 : req_tdata[7:0];
               phase_in    = (phase_inc == rsfg_pkg::PHASE_WRAP) ? '0 : phase_inc;
               count_in    = count_sat;
               pixel_in    = '0;
               dividend_in = '0;
               rem_in      = '0;
               quo_in      = '0;
               step_in     = '0;
               if (count_sat != '0) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            dividend_in = {dividend_ff[NUM_W-2:0], 1'b0};
            rem_in      = quo_bit ? rem_diff[7:0] : rem_shift[7:0];
            quo_in      = quo_next;
            step_in     = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               hue_in   = quo_next + phase_ff[7:0];
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = pixel_last;
               rsp_data_in  = {5'b00000, color.red, color.green, color.blue,
                               pixel_ext[rsfg_pkg::INDEX_W-1:0]};
               if (pixel_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pixel_in    = pixel_ff + CNT_W'(1);
                  dividend_in = {pixel_ff + CNT_W'(1), 8'h00};
                  rem_in      = '0;
                  quo_in      = '0;
                  step_in     = '0;
                  state_in    = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pixel_count_ff <= rsfg_pkg::PIXEL_COUNT_RESET;
         phase_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pixel_count_ff <= pixel_count_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spread_ff   <= spread_in;
      count_ff    <= count_in;
      pixel_ff    <= pixel_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      hue_ff      <= hue_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `RSFG_ASSERT_SAME(a_phase_range, clock, reset, 1'b1, phase_ff < rsfg_pkg::PHASE_WRAP,
                     "phase counter left its range")
   `RSFG_ASSERT_SAME(a_pixel_in_frame, clock, reset, state_ff != ST_IDLE,
                     CNT1_W'(pixel_ff) < count_ff, "pixel position beyond the frame length")
   `RSFG_ASSERT_NEXT(a_last_returns_idle, clock, reset, out_load && pixel_last,
                     state_ff == ST_IDLE, "sequencer did not return to idle after the last pixel")
   `RSFG_ASSERT_NEXT(a_start_divide, clock, reset, req_accept && (count_sat != '0),
                     state_ff == ST_DIVIDE, "frame request did not start the divider")

endmodule

### dv/rainbow_strip_frame_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rainbow strip frame generator with a built-in pixel predictor.
module rainbow_strip_frame_generator_test;

   localparam int STRIP_MAX    = rsfg_pkg::MAX_PIXELS_DEFAULT;
   localparam int STALL_LIMIT  = 3000;
   localparam int SETTLE_TIME  = 300;
   localparam int NO_CSR_WRITE = -1;

   typedef struct {
      logic [rsfg_pkg::INDEX_W-1:0] index;
      logic [rsfg_pkg::LEVEL_W-1:0] blue;
      logic [rsfg_pkg::LEVEL_W-1:0] green;
      logic [rsfg_pkg::LEVEL_W-1:0] red;
      logic                         last;
   } pixel_type;

   typedef struct {
      int                            csr_value;
      logic [rsfg_pkg::SPREAD_W-1:0] spread;
      bit                            typed;
      logic [rsfg_pkg::LEVEL_W-1:0]  red;
      logic [rsfg_pkg::LEVEL_W-1:0]  green;
      logic [rsfg_pkg::LEVEL_W-1:0]  blue;
   } stimulus_row_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               csr_valid  = 1'b0;
   logic [rsfg_pkg::PIXEL_COUNT_W-1:0] csr_data   = '0;
   logic                               req_tvalid = 1'b0;
   logic [rsfg_pkg::REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                               rsp_tready = 1'b0;
   logic                               csr_ready;
   logic                               req_tready;
   logic                               rsp_tvalid;
   logic [rsfg_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                               rsp_tlast;

   pixel_type                          pixel_queue[$];
   stimulus_row_type                   directed_rows[$];
   logic [rsfg_pkg::PIXEL_COUNT_W-1:0] strip_length = rsfg_pkg::PIXEL_COUNT_RESET;
   logic [rsfg_pkg::PHASE_W-1:0]       frame_phase  = '0;
   int                                 error_count  = 0;
   int                                 idle_cycles  = 0;
   int                                 send_calm    = 0;
   int                                 take_calm    = 0;

   always #5 clock = ~clock;

   rainbow_strip_frame_generator uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic pixel_type shade_pixel(input int position, input logic [7:0] hue,
                                             input bit last);
      int         w;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      pixel_type  p;
      w = 255 - hue;
      if (w < 85) begin
         r = 8'(255 - 3 * w);
         g = 8'd0;
         b = 8'(3 * w);
      end else if (w < 170) begin
         w = w - 85;
         r = 8'd0;
         g = 8'(3 * w);
         b = 8'(255 - 3 * w);
      end else begin
         w = w - 170;
         r = 8'(3 * w);
         g = 8'(255 - 3 * w);
         b = 8'd0;
      end
      p.index = position[rsfg_pkg::INDEX_W-1:0];
      p.blue  = b[7:3];
      p.green = g[7:3];
      p.red   = r[7:3];
      p.last  = last;
      return p;
   endfunction

   // Advances the frame phase and queues every pixel that one frame request produces.
   function automatic int render_frame(input logic [rsfg_pkg::SPREAD_W-1:0] spread);
      int         divisor;
      int         count;
      int         hue;
      logic [7:0] hue_low;
      divisor = (spread == 0) ? 1 : int'(spread);
      count   = (strip_length > STRIP_MAX) ? STRIP_MAX : int'(strip_length);
      frame_phase = frame_phase + 1'b1;
      if (frame_phase >= rsfg_pkg::PHASE_WRAP) begin
         frame_phase = '0;
      end
      for (int i = 0; i < count; i++) begin
         hue     = (i * 256) / divisor + int'(frame_phase);
         hue_low = hue[7:0];
         pixel_queue.push_back(shade_pixel(i, hue_low, (i + 1) == count));
      end
      return count;
   endfunction

   // Mostly random waits, with occasional stretches of back-to-back transactions.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm = calm - 1;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(5, 40);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic logic [rsfg_pkg::SPREAD_W-1:0] random_spread();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd1;
         3: return 8'($urandom_range(1, 8));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   task automatic send_request(input logic [rsfg_pkg::SPREAD_W-1:0] spread, output int count);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= spread;
      do @(posedge clock); while (req_tready !== 1'b1);
      count = render_frame(spread);
   endtask

   // Always waits on the clock before checking the queue, so the valid is never lowered and raised in one step.
   task automatic drain_expected();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_strip_length(input int value);
      drain_expected();
      // A frame of zero pixels leaves nothing to wait on, so give it time to finish.
      repeat (SETTLE_TIME) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= rsfg_pkg::PIXEL_COUNT_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid    <= 1'b0;
      strip_length = rsfg_pkg::PIXEL_COUNT_W'(value);
   endtask

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("rainbow_strip_frame_generator_test: FAIL");
         $finish;
      end
   end

   initial begin : pixel_sink
      int        gap;
      pixel_type want;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_wait(take_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (pixel_queue.size() == 0) begin
            report_mismatch("unexpected pixel index", rsp_tdata[3:0], NO_CSR_WRITE);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_tdata[3:0] !== want.index)
               report_mismatch("pixel_index", rsp_tdata[3:0], want.index);
            if (rsp_tdata[8:4] !== want.blue)
               report_mismatch("blue_level", rsp_tdata[8:4], want.blue);
            if (rsp_tdata[13:9] !== want.green)
               report_mismatch("green_level", rsp_tdata[13:9], want.green);
            if (rsp_tdata[18:14] !== want.red)
               report_mismatch("red_level", rsp_tdata[18:14], want.red);
            if (rsp_tlast !== want.last)
               report_mismatch("last_pixel", rsp_tlast, want.last);
         end
      end
   end

   initial begin : request_source
      int count;
      int slot;
      int value;
      // The first frame after reset has phase one, so with a wide spread pixel zero is pure red.
      directed_rows.push_back('{NO_CSR_WRITE, 8'd255, 1'b1, 5'd31, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd0, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd1, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd128, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{1, 8'd0, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd255, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{16, 8'd0, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd255, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd2, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd85, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{0, 8'd7, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd0, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd255, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{31, 8'd0, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'd255, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{17, 8'd16, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{2, 8'd170, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'hAA, 1'b0, 5'd0, 5'd0, 5'd0});
      directed_rows.push_back('{NO_CSR_WRITE, 8'h55, 1'b0, 5'd0, 5'd0, 5'd0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr_value != NO_CSR_WRITE) begin
            write_strip_length(directed_rows[r].csr_value);
         end
         send_request(directed_rows[r].spread, count);
         if (directed_rows[r].typed && count > 0) begin
            // The typed-in colors stand in for the predicted first pixel of this frame.
            slot = pixel_queue.size() - count;
            pixel_queue[slot].red   = directed_rows[r].red;
            pixel_queue[slot].green = directed_rows[r].green;
            pixel_queue[slot].blue  = directed_rows[r].blue;
         end
      end

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: value = 16;
            1: value = 1;
            2: value = 31;
            3: value = 3;
            default: value = $urandom_range(0, 31);
         endcase
         write_strip_length(value);
         repeat (23) begin
            if ($urandom_range(0, 19) == 0) begin
               drain_expected();
            end
            send_request(random_spread(), count);
         end
      end

      drain_expected();
      repeat (SETTLE_TIME) @(posedge clock);
      if (error_count == 0 && pixel_queue.size() == 0) begin
         $display("rainbow_strip_frame_generator_test: PASS");
      end else begin
         $display("rainbow_strip_frame_generator_test: FAIL");
      end
      $finish;
   end

endmodule
